/* design/utf8_ansi_text_translator_macros.svh */
// Assertion macros used by the translator controller.
// Depends on nothing; included by the files that hold assertions.
`ifndef UTF8_ANSI_TEXT_TRANSLATOR_MACROS_SVH
`define UTF8_ANSI_TEXT_TRANSLATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define UAT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define UAT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/uat_pkg.sv */
// Types and constants for the UTF-8 / ANSI text translator.
// Depends on nothing; imported by all translator modules.
package uat_pkg;

   localparam logic [7:0] ESC_CHAR   = 8'h1b;
   localparam logic [7:0] CSI_CHAR   = 8'h5b;
   localparam logic [7:0] SEMI_CHAR  = 8'h3b;
   localparam logic [7:0] SGR_CHAR   = 8'h6d;
   localparam logic [7:0] ESC_ESC_CODE = 8'h03;
   localparam logic [7:0] COLOUR_RESET = 8'h80;

   localparam logic [1:0] LAYOUT_BLOCKS = 2'd1;
   localparam logic [1:0] LAYOUT_LATIN  = 2'd2;

   localparam logic [1:0] PHASE_NORMAL = 2'd0;
   localparam logic [1:0] PHASE_ESC    = 2'd1;
   localparam logic [1:0] PHASE_CSI    = 2'd2;

   // Controller to datapath.
   typedef struct packed {
      logic take_byte;  // process the input byte
      logic sgr_start;  // start applying arguments
      logic sgr_step;   // apply one argument
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic emit;       // the byte produced a character
      logic sgr_begin;  // the byte was an 'm' ending a CSI sequence
      logic sgr_last;   // the current argument is the last one
   } status_type;

   function automatic logic [2:0] colour_map(input logic bold, input logic [2:0] idx);
      logic [2:0] c;
      case (idx)
         3'd0: c = 3'd0;
         3'd1: c = 3'd3;
         3'd2: c = 3'd0;
         3'd3: c = bold ? 3'd1 : 3'd7;
         3'd4: c = 3'd2;
         3'd5: c = 3'd6;
         3'd6: c = 3'd5;
         default: c = 3'd4;
      endcase
      return c;
   endfunction

   function automatic logic [3:0] quad_bits(input logic [3:0] idx);
      logic [3:0] q;
      case (idx)
         4'd0: q = 4'd2;
         4'd1: q = 4'd1;
         4'd2: q = 4'd8;
         4'd3: q = 4'd11;
         4'd4: q = 4'd9;
         4'd5: q = 4'd14;
         4'd6: q = 4'd13;
         4'd7: q = 4'd4;
         4'd8: q = 4'd6;
         default: q = 4'd7;
      endcase
      return q;
   endfunction

   function automatic logic [7:0] map_latin(input logic [20:0] u);
      logic [7:0] r;
      r = u[7:0];
      case (u)
         21'h5b: r = 8'h00;
         21'h5d: r = 8'h01;
         21'h5c: r = 8'h0b;
         21'ha1: r = 8'h5b;
         21'ha7: r = 8'h13;
         21'hba: r = 8'h14;
         21'hbf: r = 8'h5d;
         21'hc0, 21'he0: r = 8'h1b;
         21'hc1, 21'he1: r = 8'h16;
         21'hc2, 21'he2: r = 8'h0e;
         21'hc3, 21'he3: r = 8'h0a;
         21'hc4, 21'he4: r = 8'h05;
         21'hc7, 21'he7: r = 8'h7d;
         21'hc8, 21'he8: r = 8'h1c;
         21'hc9, 21'he9: r = 8'h17;
         21'hca, 21'hea: r = 8'h0f;
         21'hcb, 21'heb: r = 8'h06;
         21'hcc, 21'hec: r = 8'h1d;
         21'hcd, 21'hed: r = 8'h18;
         21'hce, 21'hee: r = 8'h10;
         21'hcf, 21'hef: r = 8'h09;
         21'hd1: r = 8'h5c;
         21'hd2, 21'hf2: r = 8'h1e;
         21'hd3, 21'hf3: r = 8'h19;
         21'hd4, 21'hf4: r = 8'h11;
         21'hd6, 21'hf6: r = 8'h07;
         21'hd9, 21'hf9: r = 8'h1f;
         21'hda, 21'hfa: r = 8'h1a;
         21'hdb, 21'hfb: r = 8'h12;
         21'hdc: r = 8'h7f;
         21'hdf: r = 8'h02;
         21'hf1: r = 8'h7c;
         21'hfc: r = 8'h7b;
         21'h391, 21'h3b1: r = 8'h04;
         21'h392, 21'h3b2: r = 8'h02;
         default: r = u[7:0];
      endcase
      return r;
   endfunction

endpackage

/* design/uat_ctrl.sv */
// Controller for the translator: accepts bytes, sequences SGR application,
// and holds the output register. Depends on uat_pkg.
`include "utf8_ansi_text_translator_macros.svh"

module uat_ctrl
   import uat_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] char_in,
   output logic [7:0] rsp_tdata,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [1:0] {
      ST_RUN = 2'b01,
      ST_SGR = 2'b10
   } state_type;

   state_type  state_ff, state_in;
   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       accept;

   // A byte is taken outside the SGR walk when the output slot is free or being drained.
   assign req_tready = (state_ff == ST_RUN) && (!valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd.take_byte = accept;
      cmd.sgr_start = accept && status.sgr_begin;
      cmd.sgr_step  = (state_ff == ST_SGR);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (accept && status.sgr_begin) begin
               state_in = ST_SGR;
            end
         end
         ST_SGR: begin
            if (status.sgr_last) begin
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (accept && status.emit) begin
         valid_in = 1'b1;
         data_in  = char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   `UAT_ASSERT_IMPL(a_no_take_in_sgr, clock, reset, state_ff == ST_SGR, !req_tready, "byte taken during SGR")
   `UAT_ASSERT_NEXT(a_sgr_entry, clock, reset, accept && status.sgr_begin, state_ff == ST_SGR, "SGR not entered")
   `UAT_ASSERT_NEXT(a_hold_out, clock, reset, valid_ff && !rsp_tready, valid_ff && $stable(data_ff), "result lost")

endmodule

/* design/uat_datapath.sv */
// Datapath: UTF-8 decode, escape parser, SGR argument store and attribute
// registers, character translation. Depends on uat_pkg.
module uat_datapath
   import uat_pkg::*;
#(
   parameter int MAX_ARGS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [1:0] layout,
   input  logic [7:0] req_byte,
   input  cmd_type    cmd,
   output status_type status,
   output logic [7:0] char_out
);

   localparam int IW = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ARGS - 1);

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  remain_ff, remain_in;
   logic [20:0] accum_ff, accum_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [7:0]  args_ff [MAX_ARGS];
   logic        arg_we;
   logic [IW-1:0] arg_wa;
   logic [7:0]  arg_wd;
   logic [IW-1:0] sidx_ff, sidx_in;
   logic        bold_ff, bold_in;
   logic        six_ff, six_in;
   logic [7:0]  c4_ff, c4_in;
   logic [7:0]  c6_ff, c6_in;

   // Decode stage for one raw byte (the reprocess path decodes re_byte on its own).
   logic [20:0] u1;
   logic [1:0]  rem1;
   logic        drop1;
   logic [20:0] u2;
   logic        drop2;
   logic [7:0]  re_byte;
   logic        reproc;
   logic [20:0] uf;
   logic        ufvalid;
   logic [7:0]  mapped;
   logic        emit;
   logic [7:0]  code;
   logic        sgr_begin;
   logic [11:0] digit_v;
   logic [7:0]  cur_arg;

   function automatic logic [5:0] sext_rev(input logic [5:0] n);
      logic [5:0] r;
      for (int i = 0; i < 6; i++) r[5-i] = n[i];
      return r;
   endfunction

   always_comb begin
      u1 = '0; rem1 = 2'd0; drop1 = 1'b0;
      if (remain_ff != 2'd0 && req_byte[7:6] == 2'b10) begin
         u1 = {accum_ff[14:0], req_byte[5:0]};
         rem1 = remain_ff - 2'd1;
      end else if (req_byte[7:3] == 5'b11110) begin
         rem1 = 2'd3; u1 = {18'd0, req_byte[2:0]};
      end else if (req_byte[7:4] == 4'b1110) begin
         rem1 = 2'd2; u1 = {17'd0, req_byte[3:0]};
      end else if (req_byte[7:5] == 3'b110) begin
         rem1 = 2'd1; u1 = {16'd0, req_byte[4:0]};
      end else begin
         drop1 = req_byte[7];
         u1 = {13'd0, req_byte};
      end
   end

   // Second pass after an ESC: the utf8 state is idle, so the byte is
   // either ASCII, a lead byte starting a sequence, or dropped.
   assign re_byte = u1[7:0];
   always_comb begin
      u2 = {13'd0, re_byte};
      drop2 = re_byte[7];
   end

   always_comb begin
      phase_in = phase_ff; remain_in = remain_ff; accum_in = accum_ff;
      idx_in = idx_ff; arg_we = 1'b0; arg_wa = idx_ff; arg_wd = '0;
      emit = 1'b0; code = '0; sgr_begin = 1'b0; reproc = 1'b0;
      uf = u1; ufvalid = 1'b0; digit_v = '0;
      cur_arg = args_ff[idx_ff];
      if (cmd.take_byte) begin
         remain_in = rem1;
         if (rem1 != 2'd0) begin
            accum_in = u1;
         end else if (!drop1) begin
            if (phase_ff == PHASE_ESC) begin
               if (u1 == 21'(CSI_CHAR)) begin
                  phase_in = PHASE_CSI;
                  idx_in = '0; arg_we = 1'b1; arg_wa = '0; arg_wd = '0;
               end else begin
                  phase_in = PHASE_NORMAL;
                  if (u1 == 21'(ESC_CHAR)) begin
                     emit = 1'b1; code = ESC_ESC_CODE;
                  end else begin
                     reproc = 1'b1;
                  end
               end
            end else if (phase_ff == PHASE_CSI) begin
               if (u1 >= 21'h30 && u1 <= 21'h39) begin
                  digit_v = 12'(cur_arg) * 12'd10 + 12'(u1[3:0]);
                  arg_we = 1'b1; arg_wa = idx_ff;
                  arg_wd = (digit_v > 12'd255) ? 8'hff : digit_v[7:0];
               end else if (u1 == 21'(SEMI_CHAR)) begin
                  idx_in = (idx_ff == LAST_IDX) ? LAST_IDX : idx_ff + IW'(1);
                  arg_we = 1'b1; arg_wa = idx_in; arg_wd = '0;
               end else begin
                  phase_in = PHASE_NORMAL;
                  sgr_begin = (u1 == 21'(SGR_CHAR));
               end
            end else if (u1 == 21'(ESC_CHAR)) begin
               phase_in = PHASE_ESC;
            end else begin
               ufvalid = 1'b1;
            end
         end
         if (reproc) begin
            // Reprocess the low byte as a fresh raw byte, phase now normal.
            if (re_byte[7:3] == 5'b11110) begin
               remain_in = 2'd3; accum_in = {18'd0, re_byte[2:0]};
            end else if (re_byte[7:4] == 4'b1110) begin
               remain_in = 2'd2; accum_in = {17'd0, re_byte[3:0]};
            end else if (re_byte[7:5] == 3'b110) begin
               remain_in = 2'd1; accum_in = {16'd0, re_byte[4:0]};
            end else if (!drop2) begin
               if (re_byte == ESC_CHAR) begin
                  phase_in = PHASE_ESC;
               end else begin
                  uf = u2; ufvalid = 1'b1;
               end
            end
         end
         if (ufvalid) begin
            emit = 1'b1; code = mapped;
         end
      end
   end

   // Character translation for the selected layout.
   always_comb begin
      logic [20:0] n;
      n = '0;
      mapped = uf[7:0];
      if (layout == LAYOUT_BLOCKS) begin
         if (uf == 21'h2580) mapped = c4_ff ^ 8'h0c;
         else if (uf == 21'h2584) mapped = c4_ff ^ 8'h03;
         else if (uf == 21'h2588) mapped = six_ff ? c6_ff ^ 8'h3f : c4_ff ^ 8'h0f;
         else if (uf == 21'h258c) mapped = six_ff ? c6_ff ^ 8'h2a : c4_ff ^ 8'h0a;
         else if (uf == 21'h2590) mapped = six_ff ? c6_ff ^ 8'h15 : c4_ff ^ 8'h05;
         else if (uf >= 21'h2591 && uf <= 21'h2593) mapped = six_ff ? c6_ff : c4_ff;
         else if (uf >= 21'h2596 && uf <= 21'h259f)
            mapped = c4_ff ^ {4'd0, quad_bits(4'(uf - 21'h2596))};
         else if (uf >= 21'h1fb00 && uf <= 21'h1fb3b) begin
            n = uf - 21'h1fb00 + 21'd1;
            if (n >= 21'd21) n = n + 21'd1;
            if (n >= 21'd42) n = n + 21'd1;
            mapped = c6_ff ^ {2'd0, sext_rev(n[5:0])};
         end
      end else if (layout == LAYOUT_LATIN) begin
         mapped = map_latin(uf);
      end
   end

   // SGR application: one stored argument per cycle.
   logic [7:0] a;
   logic [2:0] col;
   always_comb begin
      bold_in = bold_ff; six_in = six_ff; c4_in = c4_ff; c6_in = c6_ff;
      sidx_in = sidx_ff;
      a = args_ff[sidx_ff];
      col = colour_map(bold_ff, 3'(a - 8'd30));
      if (cmd.sgr_start) sidx_in = '0;
      if (cmd.sgr_step) begin
         sidx_in = sidx_ff + IW'(1);
         case (a)
            8'd0: begin
               bold_in = 1'b0; six_in = 1'b0; c4_in = COLOUR_RESET; c6_in = COLOUR_RESET;
            end
            8'd1:  bold_in = 1'b1;
            8'd4:  six_in = 1'b0;
            8'd6:  six_in = 1'b1;
            8'd7:  begin c4_in = c4_ff | 8'h0f; c6_in = c6_ff | 8'h3f; end
            8'd21: bold_in = 1'b0;
            8'd27: begin c4_in = c4_ff & 8'hf0; c6_in = c6_ff & 8'hc0; end
            8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37: begin
               c4_in = {1'b1, col, c4_ff[3:0]};
               c6_in = {1'b1, col[0], c6_ff[5:0]};
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_NORMAL; remain_ff <= '0; accum_ff <= '0; idx_ff <= '0;
         sidx_ff <= '0; bold_ff <= 1'b0; six_ff <= 1'b0;
         c4_ff <= COLOUR_RESET; c6_ff <= COLOUR_RESET;
      end else begin
         phase_ff <= phase_in; remain_ff <= remain_in; accum_ff <= accum_in;
         idx_ff <= idx_in; sidx_ff <= sidx_in; bold_ff <= bold_in; six_ff <= six_in;
         c4_ff <= c4_in; c6_ff <= c6_in;
      end
   end

   always_ff @(posedge clock) begin
      if (arg_we) args_ff[arg_wa] <= arg_wd;
   end

   always_comb begin
      status.emit      = emit;
      status.sgr_begin = sgr_begin;
      status.sgr_last  = (sidx_ff == idx_ff);
   end
   assign char_out = code;

endmodule

/* design/utf8_ansi_text_translator.sv */
// Top level of the UTF-8 / ANSI SGR text translator.
// Depends on uat_pkg, uat_ctrl and uat_datapath.
//
//   port group | dir | beat contents
//   req_       | in  | tdata[7:0] in_byte
//   rsp_       | out | tdata[7:0] char_code
//   csr_       | in  | wdata[1:0] layout_select
//
// An 'm' closing a CSI sequence starts the SGR sequencer, which walks the
// stored arguments (1 to MAX_ARGS) one entry a cycle; no byte is taken
// meanwhile. A result waits in the output register; the next byte is still
// taken when that register drains in the same cycle. Reset is synchronous,
// active high.
module utf8_ansi_text_translator
   import uat_pkg::*;
#(
   parameter int MAX_ARGS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_code
   input  logic       csr_wen,
   input  logic [1:0] csr_wdata
);

   logic [1:0] layout_ff, layout_in;
   cmd_type    cmd;
   status_type status;
   logic [7:0] char_code;

   // The layout register; 3 behaves as no translation.
   assign layout_in = csr_wen ? csr_wdata : layout_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= '0;
      end else begin
         layout_ff <= layout_in;
      end
   end

   uat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .char_in    (char_code),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .status     (status)
   );

   uat_datapath #(.MAX_ARGS(MAX_ARGS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .layout   (layout_ff),
      .req_byte (req_tdata),
      .cmd      (cmd),
      .status   (status),
      .char_out (char_code)
   );

endmodule

/* tb/translator_checker.sv */
// Checker for the UTF-8 / ANSI text translator: watches both streams and the
// layout register, predicts each character code and compares. Uses nothing else.
module translator_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       csr_wen,
   input  logic [1:0] csr_wdata,
   output int         fail_count,
   output int         codes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARG_SLOTS = 8;
   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_CSI    = 2'd2;

   logic [1:0]  layout;
   logic [1:0]  phase;
   int unsigned pending_cont;
   logic [20:0] accum;
   int unsigned args [ARG_SLOTS];
   int unsigned arg_at;
   logic        bold;
   logic        six_mode;
   logic [7:0]  colour4, colour6;
   logic [7:0]  code_queue[$];

   assign codes_pending = code_queue.size();

   function automatic logic [2:0] ink(logic b, int unsigned idx);
      case (idx)
         0: return 3'd0;
         1: return 3'd3;
         2: return 3'd0;
         3: return b ? 3'd1 : 3'd7;
         4: return 3'd2;
         5: return 3'd6;
         6: return 3'd5;
         default: return 3'd4;
      endcase
   endfunction

   function automatic logic [7:0] quadrant(int unsigned idx);
      logic [7:0] q [10] = '{2, 1, 8, 11, 9, 14, 13, 4, 6, 7};
      return q[idx];
   endfunction

   function automatic logic [20:0] block_glyph(logic [20:0] u);
      int unsigned n;
      logic [7:0] r;
      if (u == 21'h2580) return colour4 ^ 8'h0c;
      if (u == 21'h2584) return colour4 ^ 8'h03;
      if (u == 21'h2588) return six_mode ? colour6 ^ 8'h3f : colour4 ^ 8'h0f;
      if (u == 21'h258c) return six_mode ? colour6 ^ 8'h2a : colour4 ^ 8'h0a;
      if (u == 21'h2590) return six_mode ? colour6 ^ 8'h15 : colour4 ^ 8'h05;
      if (u >= 21'h2591 && u <= 21'h2593) return six_mode ? colour6 : colour4;
      if (u >= 21'h2596 && u <= 21'h259f) return colour4 ^ quadrant(u - 21'h2596);
      if (u >= 21'h1fb00 && u <= 21'h1fb3b) begin
         n = u - 21'h1fb00 + 1;
         if (n >= 21) n++;
         if (n >= 42) n++;
         r = 0;
         for (int i = 0; i < 6; i++) if (n[i]) r[5-i] = 1'b1;
         return colour6 ^ r;
      end
      return u;
   endfunction

   function automatic logic [7:0] latin_glyph(logic [20:0] u);
      case (u)
         21'h5b: return 8'h00;
         21'h5d: return 8'h01;
         21'h5c: return 8'h0b;
         21'ha1: return 8'h5b;
         21'ha7: return 8'h13;
         21'hba: return 8'h14;
         21'hbf: return 8'h5d;
         21'hc0, 21'he0: return 8'h1b;
         21'hc1, 21'he1: return 8'h16;
         21'hc2, 21'he2: return 8'h0e;
         21'hc3, 21'he3: return 8'h0a;
         21'hc4, 21'he4: return 8'h05;
         21'hc7, 21'he7: return 8'h7d;
         21'hc8, 21'he8: return 8'h1c;
         21'hc9, 21'he9: return 8'h17;
         21'hca, 21'hea: return 8'h0f;
         21'hcb, 21'heb: return 8'h06;
         21'hcc, 21'hec: return 8'h1d;
         21'hcd, 21'hed: return 8'h18;
         21'hce, 21'hee: return 8'h10;
         21'hcf, 21'hef: return 8'h09;
         21'hd1: return 8'h5c;
         21'hd2, 21'hf2: return 8'h1e;
         21'hd3, 21'hf3: return 8'h19;
         21'hd4, 21'hf4: return 8'h11;
         21'hd6, 21'hf6: return 8'h07;
         21'hd9, 21'hf9: return 8'h1f;
         21'hda, 21'hfa: return 8'h1a;
         21'hdb, 21'hfb: return 8'h12;
         21'hdc: return 8'h7f;
         21'hdf: return 8'h02;
         21'hf1: return 8'h7c;
         21'hfc: return 8'h7b;
         21'h391, 21'h3b1: return 8'h04;
         21'h392, 21'h3b2: return 8'h02;
         default: return u[7:0];
      endcase
   endfunction

   function automatic void run_sgr();
      int unsigned a;
      logic [2:0] c;
      for (int i = 0; i <= arg_at && i < ARG_SLOTS; i++) begin
         a = args[i];
         if (a == 0) begin
            bold = 0; six_mode = 0; colour4 = 8'h80; colour6 = 8'h80;
         end else if (a == 1) bold = 1;
         else if (a == 4) six_mode = 0;
         else if (a == 6) six_mode = 1;
         else if (a == 7) begin
            colour4 |= 8'h0f; colour6 |= 8'h3f;
         end else if (a == 21) bold = 0;
         else if (a == 27) begin
            colour4 &= 8'hf0; colour6 &= 8'hc0;
         end else if (a >= 30 && a <= 37) begin
            c = ink(bold, a - 30);
            colour4 = {1'b1, c, colour4[3:0]};
            colour6 = {1'b1, c[0], colour6[5:0]};
         end
      end
   endfunction

   // Returns 1 with a code to emit, 2 with a byte to run again, 0 otherwise.
   function automatic int decode_byte(logic [7:0] c, output logic [7:0] code);
      logic [20:0] u;
      int unsigned k, v;
      code = 0;
      if (pending_cont > 0 && c[7:6] == 2'b10) begin
         u = {accum[14:0], c[5:0]};
         pending_cont--;
      end else if (c[7:3] == 5'b11110) begin
         pending_cont = 3; u = c[2:0];
      end else if (c[7:4] == 4'b1110) begin
         pending_cont = 2; u = c[3:0];
      end else if (c[7:5] == 3'b110) begin
         pending_cont = 1; u = c[4:0];
      end else begin
         pending_cont = 0;
         if (c[7]) return 0;
         u = c;
      end
      if (pending_cont > 0) begin
         accum = u;
         return 0;
      end
      if (phase == PH_ESC) begin
         if (u == 21'h5b) begin
            phase = PH_CSI; args[0] = 0; arg_at = 0;
            return 0;
         end
         phase = PH_NORMAL;
         if (u == 21'h1b) begin
            code = 8'h03;
            return 1;
         end
         code = u[7:0];
         return 2;
      end
      if (phase == PH_CSI) begin
         if (u >= 21'h30 && u <= 21'h39) begin
            k = arg_at < ARG_SLOTS ? arg_at : ARG_SLOTS - 1;
            v = args[k] * 10 + (u - 21'h30);
            args[k] = v > 255 ? 255 : v;
         end else if (u == 21'h3b) begin
            arg_at++;
            if (arg_at >= ARG_SLOTS) arg_at = ARG_SLOTS - 1;
            args[arg_at] = 0;
         end else begin
            if (u == 21'h6d) run_sgr();
            phase = PH_NORMAL;
         end
         return 0;
      end
      if (u == 21'h1b) begin
         phase = PH_ESC;
         return 0;
      end
      if (layout == 2'd1) u = block_glyph(u);
      else if (layout == 2'd2) u = latin_glyph(u);
      code = u[7:0];
      return 1;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      int r;
      logic [7:0] code;
      if (reset) begin
         layout = 0; phase = PH_NORMAL; pending_cont = 0; accum = 0; arg_at = 0;
         foreach (args[i]) args[i] = 0;
         bold = 0; six_mode = 0; colour4 = 8'h80; colour6 = 8'h80;
         code_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_wen) layout = csr_wdata;
         // Compare the outgoing beat first: a code predicted now cannot leave yet.
         if (rsp_tvalid && rsp_tready) begin
            if (code_queue.size() == 0)
               report_mismatch($sformatf("unexpected code %h", rsp_tdata));
            else begin
               code = code_queue.pop_front();
               if (code !== rsp_tdata)
                  report_mismatch($sformatf("code %h, predicted %h", rsp_tdata, code));
            end
         end
         if (req_tvalid && req_tready) begin
            r = decode_byte(req_tdata, code);
            if (r == 2) r = decode_byte(code, code);
            if (r == 1) code_queue.push_back(code);
         end
      end
   end
endmodule

/* tb/testbench.sv */
// Top of the translator testbench: clock, reset, byte stimulus and verdict.
// Depends on utf8_ansi_text_translator (and uat_pkg) and translator_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import uat_pkg::*;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_tvalid = 0;
   logic       req_tready;
   logic [7:0] req_tdata = 0;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 0;
   logic [7:0] rsp_tdata;       // [7:0] char_code
   logic       csr_wen = 0;
   logic [1:0] csr_wdata = 0;
   int         fail_count;
   int         codes_pending;
   logic [7:0] text_bytes[$];   // bytes waiting to be sent as beats

   utf8_ansi_text_translator DUT (.*);

   translator_checker checker_i (.*);

   initial forever #1 clock = ~clock;

   // Most gaps are short; now and then a long one.
   function automatic int pause_len();
      int p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // The receiver stalls at random, with calm stretches where it never stalls.
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
         stall = pause_len();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Sends every queued byte; gaps fall between beats unless told otherwise.
   task automatic send_text(input bit steady);
      int gap;
      while (text_bytes.size() > 0) begin
         gap = steady ? 0 : pause_len();
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= text_bytes.pop_front();
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic add_bytes(input logic [7:0] b[$]);
      foreach (b[i]) text_bytes.push_back(b[i]);
   endtask

   // Appends the UTF-8 form of a code point.
   task automatic add_utf8(input logic [20:0] u);
      if (u < 21'h80) text_bytes.push_back(u[7:0]);
      else if (u < 21'h800) add_bytes('{{3'b110, u[10:6]}, {2'b10, u[5:0]}});
      else if (u < 21'h10000)
         add_bytes('{{4'b1110, u[15:12]}, {2'b10, u[11:6]}, {2'b10, u[5:0]}});
      else add_bytes('{{5'b11110, u[20:18]}, {2'b10, u[17:12]},
                       {2'b10, u[11:6]}, {2'b10, u[5:0]}});
   endtask

   // Appends a CSI sequence, mostly SGR, with a few random args, some oversized.
   task automatic add_sgr();
      int n = $urandom_range(1, 10);
      int codes [12] = '{0, 1, 4, 6, 7, 21, 27, 30, 33, 37, 255, 999};
      int a;
      string digits;
      add_bytes('{ESC_CHAR, CSI_CHAR});
      for (int i = 0; i < n; i++) begin
         if (i > 0) text_bytes.push_back(SEMI_CHAR);
         a = $urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : codes[$urandom_range(0, 11)];
         if (a != 0 || $urandom_range(0, 1)) begin
            digits = $sformatf("%0d", a);
            for (int k = 0; k < digits.len(); k++) text_bytes.push_back(digits[k]);
         end
      end
      text_bytes.push_back($urandom_range(0, 7) == 0 ? 8'h41 : SGR_CHAR);
   endtask

   // Writes the layout only once all codes are out and the SGR walk is done.
   task automatic set_layout(input logic [1:0] value);
      while (codes_pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [20:0] pick_point();
      case ($urandom_range(0, 7))
         0: return $urandom_range(21'h20, 21'h7e);
         1: return $urandom_range(21'h80, 21'hff);
         2: return $urandom_range(21'h2580, 21'h25a0);
         3: return $urandom_range(21'h1fb00, 21'h1fb3c);
         4: return $urandom_range(21'h390, 21'h3b3);
         5: return $urandom_range(21'h100, 21'hffff);
         6: return $urandom_range(21'h10000, 21'h10ffff);
         default: return $urandom_range(21'h0, 21'h1fffff);
      endcase
   endfunction

   initial begin
      logic [1:0] plan [4] = '{LAYOUT_BLOCKS, LAYOUT_LATIN, 2'd3, 2'd0};
      int r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, stray and truncated sequences, escapes, SGR overflow.
      set_layout(LAYOUT_BLOCKS);
      add_bytes('{8'h00, 8'h7f, 8'hff, 8'h80, 8'he2, 8'h41, 8'hc3, 8'he2, 8'h96, 8'h88});
      add_bytes('{ESC_CHAR, ESC_CHAR, ESC_CHAR, 8'h5a, ESC_CHAR, 8'hc3, 8'ha9});
      add_bytes('{ESC_CHAR, CSI_CHAR, "9", "9", "9", ";", "3", "1", ";", "6", ";", ";",
                  ";", ";", ";", ";", ";", "7", "m"});
      add_utf8(21'h1fb15); add_utf8(21'h1fb3b); add_utf8(21'h10ffff);
      send_text(1'b0);

      // Random part: mostly well-formed text with escapes, some raw noise.
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         set_layout(plan[phase_no]);
         for (int n = 0; n < 35; n++) begin
            r = $urandom_range(0, 9);
            if (r < 5) add_utf8(pick_point());
            else if (r < 7) add_sgr();
            else if (r < 8) add_bytes('{ESC_CHAR, 8'($urandom_range(0, 255))});
            else text_bytes.push_back(8'($urandom_range(0, 255)));
         end
         send_text($urandom_range(0, 3) == 0);
      end

      while (codes_pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #400us;
      $display("tb: failure");
      $finish;
   end
endmodule
